// ===== rtl/mi4inv_pkg.sv =====
// Shared constants and index helpers for the 4x4 adjugate matrix inverter.
package mi4inv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W = 32;
	localparam int COF_W = 97;
	localparam int MAG_W = 96;
	localparam int DET_W = 130;
	localparam int PROD_W = 65;

	// n-th index in 0..3 that skips x (n in 0..2)
	function automatic logic [1:0] other_idx(input logic [1:0] x, input logic [1:0] n);
		logic [1:0] r;
		r = n + ((n >= x) ? 2'd1 : 2'd0);
		return r;
	endfunction

endpackage

// ===== rtl/mi4inv_ram.sv =====
// Generic single write port RAM with registered read.
module mi4inv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/matrix4_inverse_cofactor_top.sv =====
// 4x4 matrix inverter by the adjugate method, top level.
//
// Sixteen Q(32-F).F words are taken in row-major order while busy is low, one per
// cycle in which start is high. The sixteenth word raises busy; the block then forms
// all sixteen cofactors and the determinant (from the four first-row cofactors)
// exactly on one shared 32x33 multiplier, then divides each cofactor by the
// determinant with a restoring divider that retires one quotient bit per cycle.
// A singular matrix gives the identity at one result per cycle. Each result word
// is on the outputs for one cycle with valid high and cannot be held off. busy
// falls with the last word.
module matrix4_inverse_cofactor_top #(
	parameter int FRAC_BITS = mi4inv_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] element,
	output logic        valid,
	output logic signed [31:0] inverse_element,
	output logic        invertible,
	output logic        last_of_run
);
	import mi4inv_pkg::*;

	localparam int NB = MAG_W + 2 * FRAC_BITS;
	localparam int CNT_W = $clog2(NB);

	typedef enum logic [2:0] {
		ST_LOAD, ST_COF, ST_DET, ST_PREP, ST_DRD, ST_DINIT, ST_DIT, ST_DOUT
	} state_t;

	state_t            state_q;
	logic [3:0]        st_q;
	logic [1:0]        k_q;
	logic [3:0]        cidx_q;
	logic [3:0]        oidx_q;
	logic [3:0]        lcnt_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              valid_q;
	logic signed [31:0] res_q;
	logic              invertible_q;
	logic              last_q;

	// datapath
	logic signed [31:0]        opa_q;
	logic signed [32:0]        opb_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  m2_q;
	logic signed [COF_W-1:0]   acc_q;
	logic signed [DET_W-1:0]   det_q;
	logic [DET_W-1:0]          den_q;
	logic                      det_neg_q;
	logic                      det_zero_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          num_q;
	logic [DET_W-1:0]          rem_q;
	logic [32:0]               quo_q;
	logic                      high_q;

	logic              accept;
	logic [1:0]        row, col, rr0, ra, rb, cck, cp, cq;
	logic [1:0]        rd_row, rd_col;
	logic [31:0]       m_rdata;
	logic [COF_W-1:0]  c_rdata;
	logic              acc_sub;
	logic [DET_W-1:0]  rem2;
	logic              ge;
	logic [33:0]       mag;
	logic              rnd;
	logic [31:0]       sat_res;
	logic signed [COF_W-1:0] cof_s;
	logic [COF_W-1:0]  cof_mag;

	assign accept = start && (state_q == ST_LOAD);
	assign busy = (state_q != ST_LOAD);
	assign valid = valid_q;
	assign inverse_element = res_q;
	assign invertible = invertible_q;
	assign last_of_run = last_q;

	// minor index selection
	always_comb begin
		row = cidx_q[3:2];
		col = cidx_q[1:0];
		rr0 = other_idx(row, 2'd0);
		ra  = other_idx(row, 2'd1);
		rb  = other_idx(row, 2'd2);
		cck = other_idx(col, k_q);
		cp  = other_idx(col, (k_q == 2'd0) ? 2'd1 : 2'd0);
		cq  = other_idx(col, (k_q == 2'd2) ? 2'd1 : 2'd2);
		rd_row = rr0;
		rd_col = cck;
		if (state_q == ST_DET) begin
			rd_row = 2'd0;
			rd_col = col;
		end else begin
			case (st_q)
				4'd0: begin rd_row = ra; rd_col = cp; end
				4'd1: begin rd_row = rb; rd_col = cq; end
				4'd2: begin rd_row = ra; rd_col = cq; end
				4'd3: begin rd_row = rb; rd_col = cp; end
				default: begin rd_row = rr0; rd_col = cck; end
			endcase
		end
		acc_sub = k_q[0] ^ row[0] ^ col[0];
	end

	mi4inv_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_mat_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (lcnt_q),
		.wdata (element),
		.raddr ({rd_row, rd_col}),
		.rdata (m_rdata)
	);

	mi4inv_ram #(.WIDTH(COF_W), .DEPTH(16)) u_cof_ram (
		.clk   (clk),
		.we    ((state_q == ST_COF) && (st_q == 4'd11)),
		.waddr (cidx_q),
		.wdata (acc_q),
		.raddr ({oidx_q[1:0], oidx_q[3:2]}),
		.rdata (c_rdata)
	);

	always_comb begin
		rem2 = {rem_q[DET_W-2:0], num_q[MAG_W-1]};
		ge = (rem2 >= den_q);
		rnd = ({rem_q[DET_W-2:0], 1'b0} >= den_q);
		mag = {1'b0, quo_q} + {33'd0, rnd};
		if (!neg_q) begin
			sat_res = (high_q || mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		end else begin
			sat_res = (high_q || mag > 34'h080000000) ? 32'h80000000 : 32'd0 - mag[31:0];
		end
		cof_s = c_rdata;
		cof_mag = cof_s[COF_W-1] ? COF_W'(-cof_s) : c_rdata;
	end

	always_ff @(posedge clk) begin
		prod_q <= opa_q * opb_q;
		case (state_q)
			ST_COF: begin
				case (st_q)
					4'd0: if (k_q == 2'd0) acc_q <= '0;
					4'd1: opa_q <= m_rdata;
					4'd2: opb_q <= {m_rdata[31], m_rdata};
					4'd3: opa_q <= m_rdata;
					4'd4: begin
						m2_q <= prod_q;
						opb_q <= {m_rdata[31], m_rdata};
					end
					4'd6: begin
						m2_q <= m2_q - prod_q;
						opa_q <= m_rdata;
					end
					4'd7: opb_q <= {1'b0, m2_q[31:0]};
					4'd8: opb_q <= m2_q[64:32];
					4'd9: acc_q <= acc_sub ? acc_q - COF_W'(prod_q) : acc_q + COF_W'(prod_q);
					4'd10: acc_q <= acc_sub ? acc_q - (COF_W'(prod_q) <<< 32)
						: acc_q + (COF_W'(prod_q) <<< 32);
					default: ;
				endcase
				if ((st_q == 4'd11) && (cidx_q == 4'd0)) det_q <= '0;
			end
			ST_DET: begin
				case (st_q)
					4'd1: begin
						opa_q <= m_rdata;
						opb_q <= {1'b0, acc_q[31:0]};
					end
					4'd2: opb_q <= {1'b0, acc_q[63:32]};
					4'd3: begin
						det_q <= det_q + DET_W'(prod_q);
						opb_q <= acc_q[96:64];
					end
					4'd4: det_q <= det_q + (DET_W'(prod_q) <<< 32);
					4'd5: det_q <= det_q + (DET_W'(prod_q) <<< 64);
					default: ;
				endcase
			end
			ST_PREP: begin
				det_neg_q <= det_q[DET_W-1];
				det_zero_q <= (det_q == '0);
				den_q <= det_q[DET_W-1] ? DET_W'(-det_q) : det_q;
			end
			ST_DINIT: begin
				neg_q <= c_rdata[COF_W-1] ^ det_neg_q;
				num_q <= cof_mag[MAG_W-1:0];
				rem_q <= '0;
				quo_q <= '0;
				high_q <= 1'b0;
			end
			ST_DIT: begin
				rem_q <= ge ? rem2 - den_q : rem2;
				quo_q <= {quo_q[31:0], ge};
				high_q <= high_q | quo_q[32];
				num_q <= {num_q[MAG_W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			st_q <= '0;
			k_q <= '0;
			cidx_q <= '0;
			oidx_q <= '0;
			lcnt_q <= '0;
			cnt_q <= '0;
			valid_q <= 1'b0;
			res_q <= '0;
			invertible_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						lcnt_q <= lcnt_q + 4'd1;
						if (lcnt_q == 4'd15) begin
							state_q <= ST_COF;
							st_q <= '0;
							k_q <= '0;
							cidx_q <= '0;
						end
					end
				end
				ST_COF: begin
					if (st_q == 4'd10) begin
						if (k_q == 2'd2) begin
							st_q <= 4'd11;
						end else begin
							k_q <= k_q + 2'd1;
							st_q <= '0;
						end
					end else if (st_q == 4'd11) begin
						st_q <= '0;
						k_q <= '0;
						if (cidx_q[3:2] == 2'd0) begin
							state_q <= ST_DET;
						end else if (cidx_q == 4'd15) begin
							state_q <= ST_PREP;
						end else begin
							cidx_q <= cidx_q + 4'd1;
						end
					end else begin
						st_q <= st_q + 4'd1;
					end
				end
				ST_DET: begin
					if (st_q == 4'd5) begin
						st_q <= '0;
						cidx_q <= cidx_q + 4'd1;
						state_q <= ST_COF;
					end else begin
						st_q <= st_q + 4'd1;
					end
				end
				ST_PREP: begin
					oidx_q <= '0;
					state_q <= ST_DRD;
				end
				ST_DRD: begin
					if (det_zero_q) begin
						valid_q <= 1'b1;
						res_q <= (oidx_q[3:2] == oidx_q[1:0]) ? (32'd1 << FRAC_BITS) : 32'd0;
						invertible_q <= 1'b0;
						last_q <= (oidx_q == 4'd15);
						oidx_q <= oidx_q + 4'd1;
						if (oidx_q == 4'd15) state_q <= ST_LOAD;
					end else begin
						state_q <= ST_DINIT;
					end
				end
				ST_DINIT: begin
					cnt_q <= CNT_W'(NB - 1);
					state_q <= ST_DIT;
				end
				ST_DIT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DOUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DOUT: begin
					valid_q <= 1'b1;
					res_q <= sat_res;
					invertible_q <= 1'b1;
					last_q <= (oidx_q == 4'd15);
					oidx_q <= oidx_q + 4'd1;
					state_q <= (oidx_q == 4'd15) ? ST_LOAD : ST_DRD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the 4x4 adjugate matrix inverter: self-checking against a built-in predictor.
`timescale 1ns / 100ps
module tb;
	import mi4inv_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int WIDE = 200;

	typedef logic signed [WIDE-1:0] wide_t;
	typedef struct packed {
		logic signed [31:0] value;
		logic               inv;
		logic               last;
	} inv_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] element = '0;
	logic busy, valid, invertible, last_of_run;
	logic signed [31:0] inverse_element;

	logic signed [31:0] mat [16];
	int load_idx = 0;
	inv_word_t inverse_q [$];
	int sender_gap_pct = 0;
	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int runs_singular = 0;
	int runs_total = 0;

	matrix4_inverse_cofactor_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .element(element),
		.valid(valid), .inverse_element(inverse_element), .invertible(invertible),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout");
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic wide_t at(int r, int c);
		wide_t w;
		w = mat[r*4 + c];
		return w;
	endfunction

	function automatic wide_t cof(int r, int c);
		int rr [3];
		int cc [3];
		int n;
		wide_t t0, t1, t2, s;
		n = 0;
		for (int k = 0; k < 4; k++) if (k != r) begin rr[n] = k; n++; end
		n = 0;
		for (int k = 0; k < 4; k++) if (k != c) begin cc[n] = k; n++; end
		t0 = at(rr[1], cc[1]) * at(rr[2], cc[2]) - at(rr[1], cc[2]) * at(rr[2], cc[1]);
		t1 = at(rr[1], cc[0]) * at(rr[2], cc[2]) - at(rr[1], cc[2]) * at(rr[2], cc[0]);
		t2 = at(rr[1], cc[0]) * at(rr[2], cc[1]) - at(rr[1], cc[1]) * at(rr[2], cc[0]);
		s = at(rr[0], cc[0]) * t0 - at(rr[0], cc[1]) * t1 + at(rr[0], cc[2]) * t2;
		if ((r + c) & 1) s = -s;
		return s;
	endfunction

	function automatic logic signed [31:0] div_round_sat(wide_t num, wide_t den);
		logic neg;
		logic [WIDE-1:0] n, d, q, rm;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = n / d;
		rm = n % d;
		if ((rm << 1) >= d) q = q + 1;
		if (!neg) return (q > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
		if (q > 64'h80000000) return 32'sh80000000;
		return -q[31:0];
	endfunction

	task automatic predict_inverse();
		wide_t c [16];
		wide_t det;
		inv_word_t w;
		det = '0;
		for (int k = 0; k < 16; k++) c[k] = cof(k / 4, k % 4);
		for (int j = 0; j < 4; j++) det = det + at(0, j) * c[j];
		runs_total++;
		if (det == 0) runs_singular++;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				if (det == 0) begin
					w.value = (i == j) ? (32'sd1 <<< FB) : 32'sd0;
					w.inv = 1'b0;
				end else begin
					w.value = div_round_sat(c[j*4 + i] <<< (2*FB), det);
					w.inv = 1'b1;
				end
				w.last = (i == 3 && j == 3);
				inverse_q.push_back(w);
			end
	endtask

	// result checker, sampled mid-cycle
	always @(negedge clk) begin
		inv_word_t e;
		if (arst_n && valid) begin
			words_checked++;
			if (inverse_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %0d", inverse_element);
			end else begin
				e = inverse_q.pop_front();
				if (e.value !== inverse_element || e.inv !== invertible ||
						e.last !== last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h inv %b last %b, got %h inv %b last %b",
							e.value, e.inv, e.last, inverse_element, invertible,
							last_of_run);
				end
			end
		end
	end

	// called at a rising edge; leaves start high on return
	task automatic send_word(logic signed [31:0] v);
		logic acc;
		if ($urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		element <= v;
		do begin
			@(negedge clk);
			acc = !busy;
			@(posedge clk);
		end while (!acc);
		words_sent++;
		mat[load_idx] = v;
		load_idx++;
		if (load_idx == 16) begin
			load_idx = 0;
			predict_inverse();
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_matrix(logic signed [31:0] m [16]);
		for (int k = 0; k < 16; k++) send_word(m[k]);
	endtask

	task automatic test_singular_extremes();
		logic signed [31:0] m [16];
		for (int k = 0; k < 16; k++) m[k] = (k % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
		send_matrix(m);
	endtask

	task automatic test_saturating_diagonal();
		logic signed [31:0] m [16];
		for (int k = 0; k < 16; k++) m[k] = '0;
		m[0] = 32'sd1;
		m[5] = -32'sd1;
		m[10] = 32'sh7FFFFFFF;
		m[15] = 32'sh80000000;
		send_matrix(m);
	endtask

	task automatic random_matrix();
		logic signed [31:0] m [16];
		int kind;
		kind = $urandom_range(9);
		for (int k = 0; k < 16; k++)
			case (kind)
				0, 1, 2: m[k] = $urandom;
				3, 4, 5, 6: m[k] = $signed($urandom_range(16, 0) - 8) <<< FB;
				default: m[k] = $signed($urandom_range(65535, 0)) - 32768 <<< 4;
			endcase
		if ($urandom_range(9) == 0)
			for (int k = 0; k < 4; k++) m[12 + k] = m[4 + k];
		send_matrix(m);
	endtask

	task automatic test_random_phase(int pct, int runs);
		sender_gap_pct = pct;
		for (int n = 0; n < runs; n++) random_matrix();
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_singular_extremes();
		test_saturating_diagonal();
		drain();
		test_random_phase(18, 9);
		test_random_phase(66, 9);
		test_random_phase(0, 9);
		drain();
		$display("%0d words sent, %0d inverse words checked over %0d matrices (%0d singular)",
			words_sent, words_checked, runs_total, runs_singular);
		if (mismatches == 0 && inverse_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mi4inv_pkg.sv
rtl/mi4inv_ram.sv
rtl/matrix4_inverse_cofactor_top.sv
tb/sv/tb.sv
